FILE: hdl/fpo_pkg.sv
// Shared definitions for the finder pattern orderer.
// Coordinate width default, resolve mode codes and the cross-product sign flags.
package fpo_pkg;

    localparam int COORD_BITS_DEF = 12;

    typedef enum logic [1:0] {
        MODE_DIST  = 2'd0,
        MODE_CROSS = 2'd1
    } t_mode;

    // sign of cross(0,1,2)
    typedef struct packed {
        logic neg;
        logic pos;
    } t_xflags;

endpackage

FILE: hdl/finder_pattern_orderer.sv
// Finder pattern orderer: assigns top-left, top-right and bottom-left roles
// to three QR finder pattern centres. Uses fpo_pkg, fpo_lane, fpo_cross, fpo_merge.
//
// Input channel: six coordinates, transferred when i_in_valid is high and
// o_in_stall is low. Output channel: three role indices and resolve mode,
// transferred when o_out_valid is high and i_out_stall is low.
// One result per input item, in order.
// Throughput: one item per cycle while the output is not stalled. Stages: a
// square/product stage, a sum stage, COORD_BITS + 1 square root stages (one
// root bit each, three lanes in parallel) and the output register of the
// merging stage.
// Each stage holds only while it and every stage after it are full and the
// receiver stalls, so bubbles close up; o_in_stall rises only when the whole
// pipeline is full and the output is stalled.
// Synchronous active-low reset clears the stage valid bits; data registers
// are not reset.
module finder_pattern_orderer #(
    parameter int COORD_BITS = fpo_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_p0_x,
    input  logic [COORD_BITS-1:0] i_p0_y,
    input  logic [COORD_BITS-1:0] i_p1_x,
    input  logic [COORD_BITS-1:0] i_p1_y,
    input  logic [COORD_BITS-1:0] i_p2_x,
    input  logic [COORD_BITS-1:0] i_p2_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_top_left_index,
    output logic [1:0]            o_top_right_index,
    output logic [1:0]            o_bottom_left_index,
    output logic [1:0]            o_resolve_mode
);
    import fpo_pkg::*;

    localparam int N = COORD_BITS + 4;

    logic [N-1:0]          r_vld;
    logic [N-1:0]          w_en;
    logic [COORD_BITS:0]   w_d01;
    logic [COORD_BITS:0]   w_d12;
    logic [COORD_BITS:0]   w_d02;
    t_xflags               w_flags;
    t_mode                 w_mode;

    for (genvar i = 0; i < N; i++) begin : g_en
        assign w_en[i] = ~(&r_vld[N-1:i]) | ~i_out_stall;
    end

    assign o_in_stall  = ~w_en[0];
    assign o_out_valid = r_vld[N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < N; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    fpo_lane #(.COORD_BITS(COORD_BITS)) u_lane01 (
        .i_clk (i_clk), .i_en (w_en[N-2:0]),
        .i_ax (i_p0_x), .i_ay (i_p0_y), .i_bx (i_p1_x), .i_by (i_p1_y),
        .o_dist (w_d01)
    );

    fpo_lane #(.COORD_BITS(COORD_BITS)) u_lane12 (
        .i_clk (i_clk), .i_en (w_en[N-2:0]),
        .i_ax (i_p1_x), .i_ay (i_p1_y), .i_bx (i_p2_x), .i_by (i_p2_y),
        .o_dist (w_d12)
    );

    fpo_lane #(.COORD_BITS(COORD_BITS)) u_lane02 (
        .i_clk (i_clk), .i_en (w_en[N-2:0]),
        .i_ax (i_p0_x), .i_ay (i_p0_y), .i_bx (i_p2_x), .i_by (i_p2_y),
        .o_dist (w_d02)
    );

    fpo_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .i_clk (i_clk), .i_en (w_en[N-2:0]),
        .i_x0 (i_p0_x), .i_y0 (i_p0_y),
        .i_x1 (i_p1_x), .i_y1 (i_p1_y),
        .i_x2 (i_p2_x), .i_y2 (i_p2_y),
        .o_flags (w_flags)
    );

    fpo_merge #(.COORD_BITS(COORD_BITS)) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en[N-1]),
        .i_d01   (w_d01),
        .i_d12   (w_d12),
        .i_d02   (w_d02),
        .i_flags (w_flags),
        .o_tl    (o_top_left_index),
        .o_tr    (o_top_right_index),
        .o_bl    (o_bottom_left_index),
        .o_mode  (w_mode)
    );

    assign o_resolve_mode = w_mode;

    // roles always form a permutation of the three points
    a_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_top_left_index != o_top_right_index) &&
                        (o_top_left_index != o_bottom_left_index) &&
                        (o_top_right_index != o_bottom_left_index) &&
                        (o_top_left_index != 2'd3) && (o_top_right_index != 2'd3) &&
                        (o_bottom_left_index != 2'd3))
        else $error("role indices are not a permutation");

    // both cross-product fallback orders leave point 2 bottom-left
    a_cross_bl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_resolve_mode == MODE_CROSS) |-> (o_bottom_left_index == 2'd2))
        else $error("cross fallback gave wrong bottom-left");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a transfer into a stalled full pipeline must not happen
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipeline full and stalled");

endmodule

FILE: hdl/fpo_lane.sv
// One distance lane: squared distance of a point pair, then a pipelined
// integer square root producing one root bit per stage. Uses fpo_pkg.
module fpo_lane #(
    parameter int COORD_BITS = fpo_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic [COORD_BITS+2:0]   i_en,
    input  logic [COORD_BITS-1:0]   i_ax,
    input  logic [COORD_BITS-1:0]   i_ay,
    input  logic [COORD_BITS-1:0]   i_bx,
    input  logic [COORD_BITS-1:0]   i_by,
    output logic [COORD_BITS:0]     o_dist
);
    import fpo_pkg::*;

    localparam int R  = COORD_BITS + 1;
    localparam int SW = 2 * R;
    localparam int QB = 2 * COORD_BITS;

    logic signed [COORD_BITS:0]     w_dx;
    logic signed [COORD_BITS:0]     w_dy;
    logic signed [2*COORD_BITS+1:0] w_sqx;
    logic signed [2*COORD_BITS+1:0] w_sqy;
    logic [QB-1:0]                  r_sqx;
    logic [QB-1:0]                  r_sqy;
    logic [SW-1:0]                  r_sum;
    logic [SW-1:0]                  r_v   [R-1];
    logic [R+1:0]                   r_rem [R-1];
    logic [R-1:0]                   r_q   [R];

    assign w_dx  = $signed({1'b0, i_ax}) - $signed({1'b0, i_bx});
    assign w_dy  = $signed({1'b0, i_ay}) - $signed({1'b0, i_by});
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sqx <= w_sqx[QB-1:0];
            r_sqy <= w_sqy[QB-1:0];
        end
        if (i_en[1]) begin
            r_sum <= {2'b00, r_sqx} + {2'b00, r_sqy};
        end
    end

    // restoring square root, two radicand bits brought down per stage
    for (genvar s = 0; s < R; s++) begin : g_step
        logic [SW-1:0] w_vin;
        logic [R-1:0]  w_qin;
        logic [R+1:0]  w_rin;
        logic [R+3:0]  w_rsh;
        logic [R+3:0]  w_trial;
        logic          w_ge;

        if (s == 0) begin : g_first
            assign w_vin = r_sum;
            assign w_qin = '0;
            assign w_rin = '0;
        end else begin : g_next
            assign w_vin = r_v[s-1];
            assign w_qin = r_q[s-1];
            assign w_rin = r_rem[s-1];
        end

        assign w_rsh   = {w_rin, w_vin[SW-1 -: 2]};
        assign w_trial = {2'b00, w_qin, 2'b01};
        assign w_ge    = (w_rsh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en[2+s]) begin
                r_q[s] <= {w_qin[R-2:0], w_ge};
            end
        end

        if (s < R - 1) begin : g_carry
            logic [R+3:0] w_rnew;
            assign w_rnew = w_ge ? (w_rsh - w_trial) : w_rsh;
            always_ff @(posedge i_clk) begin
                if (i_en[2+s]) begin
                    r_v[s]   <= {w_vin[SW-3:0], 2'b00};
                    r_rem[s] <= w_rnew[R+1:0];
                end
            end
        end
    end

    assign o_dist = r_q[R-1];

endmodule

FILE: hdl/fpo_cross.sv
// Sign of cross(0,1,2) for the point triple, delayed to line up with the
// distance lanes. Uses fpo_pkg for the flag struct.
module fpo_cross #(
    parameter int COORD_BITS = fpo_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [COORD_BITS+2:0] i_en,
    input  logic [COORD_BITS-1:0] i_x0,
    input  logic [COORD_BITS-1:0] i_y0,
    input  logic [COORD_BITS-1:0] i_x1,
    input  logic [COORD_BITS-1:0] i_y1,
    input  logic [COORD_BITS-1:0] i_x2,
    input  logic [COORD_BITS-1:0] i_y2,
    output fpo_pkg::t_xflags      o_flags
);
    import fpo_pkg::*;

    localparam int R = COORD_BITS + 1;

    logic signed [COORD_BITS:0]     w_bx;
    logic signed [COORD_BITS:0]     w_by;
    logic signed [COORD_BITS:0]     w_cx;
    logic signed [COORD_BITS:0]     w_cy;
    logic signed [2*COORD_BITS+1:0] r_p1;
    logic signed [2*COORD_BITS+1:0] r_p2;
    logic signed [2*COORD_BITS+2:0] w_k;
    t_xflags                        r_fl [R+1];

    assign w_bx = $signed({1'b0, i_x1}) - $signed({1'b0, i_x0});
    assign w_by = $signed({1'b0, i_y1}) - $signed({1'b0, i_y0});
    assign w_cx = $signed({1'b0, i_x2}) - $signed({1'b0, i_x0});
    assign w_cy = $signed({1'b0, i_y2}) - $signed({1'b0, i_y0});
    assign w_k  = r_p1 - r_p2;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p1 <= w_bx * w_cy;
            r_p2 <= w_by * w_cx;
        end
        if (i_en[1]) begin
            r_fl[0].neg <= w_k[2*COORD_BITS+2];
            r_fl[0].pos <= ~w_k[2*COORD_BITS+2] & (w_k != '0);
        end
    end

    // delay line matching the square root stages
    for (genvar k = 1; k <= R; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_en[1+k]) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    assign o_flags = r_fl[R];

endmodule

FILE: hdl/fpo_merge.sv
// Merging stage: picks roles from the three lane distances and the cross
// sign, applies the orientation swap, registers the result. Uses fpo_pkg.
module fpo_merge #(
    parameter int COORD_BITS = fpo_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [COORD_BITS:0] i_d01,
    input  logic [COORD_BITS:0] i_d12,
    input  logic [COORD_BITS:0] i_d02,
    input  fpo_pkg::t_xflags    i_flags,
    output logic [1:0]          o_tl,
    output logic [1:0]          o_tr,
    output logic [1:0]          o_bl,
    output fpo_pkg::t_mode      o_mode
);
    import fpo_pkg::*;

    logic [1:0] n_tl;
    logic [1:0] n_tr;
    logic [1:0] n_bl;
    t_mode      n_mode;
    logic       w_swap;

    // swap condition is the sign of cross(bl,tl,tr), i.e. cross(0,1,2)
    // negated for an odd ordering of (bl,tl,tr)
    always_comb begin
        n_mode = MODE_DIST;
        w_swap = 1'b0;
        if (i_d12 > i_d01 && i_d12 > i_d02) begin
            n_tl = 2'd0; n_bl = 2'd1; n_tr = 2'd2;
            w_swap = i_flags.pos;
        end else if (i_d01 > i_d12 && i_d01 > i_d02) begin
            n_tl = 2'd2; n_bl = 2'd1; n_tr = 2'd0;
            w_swap = i_flags.neg;
        end else if (i_d02 > i_d12 && i_d02 > i_d01) begin
            n_tl = 2'd1; n_bl = 2'd0; n_tr = 2'd2;
            w_swap = i_flags.neg;
        end else if (!i_flags.neg) begin
            n_tl = 2'd0; n_tr = 2'd1; n_bl = 2'd2;
            n_mode = MODE_CROSS;
        end else begin
            n_tl = 2'd1; n_tr = 2'd0; n_bl = 2'd2;
            n_mode = MODE_CROSS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tl   <= n_tl;
            o_tr   <= w_swap ? n_bl : n_tr;
            o_bl   <= w_swap ? n_tr : n_bl;
            o_mode <= n_mode;
        end
    end

endmodule
